// ----- hdl/pll_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pll_pkg: shared definitions for the positional list engine
// Operation codes, status codes, controller states and the per-cell command.
// ----------------------------------------------------------------------------
package pll_pkg;

    // Operation codes carried on s_operation.
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_GET    = 3'd2;
    localparam logic [2:0] OP_LOCATE = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // Status codes carried on m_status.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_POS = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        PLL_IDLE,
        PLL_EXEC,
        PLL_RESP
    } pll_state_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic exec;   // execute cycle: cells update their match flag
        logic ins;    // accepted insert
        logic del;    // accepted delete
        logic cmp;    // locate compare
    } pll_cmd_t;

endpackage
`default_nettype wire

// ----- hdl/positional_list_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine: fixed-capacity ordered list with 1-based positions
// Insert, delete, get, locate and clear on a chain of storage cells.
// ----------------------------------------------------------------------------
// Each beat is accepted in the idle state; in the execute state every cell
// of the chain shifts or compares in parallel, and the result state loads
// the result register; the next beat is accepted as soon as that register is
// loaded, even while that result still waits for m_ready. A result that is
// held back by m_ready keeps the block in its result cycle until the result
// register frees up. The list holds CAPACITY entries; an insert at a legal
// position into a full list reports status 2 and leaves the list as it was.
// ----------------------------------------------------------------------------
module positional_list_engine #(
    parameter int CAPACITY = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire [2:0]   s_operation,
    input  wire [7:0]   s_position,
    input  wire [31:0]  s_value,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_read_value,
    output logic [4:0]  m_found_position,
    output logic [4:0]  m_list_length
);

    localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int PW   = (CW + 1 > 8) ? CW + 1 : 8;
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    pll_pkg::pll_state_t state_reg, state_next;

    logic [2:0]    op_reg;
    logic [7:0]    pos_reg;
    logic [31:0]   val_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    status_reg, status_next;
    logic [31:0]   rd_reg, rd_next;

    logic          m_valid_reg, m_valid_next;
    logic [1:0]    m_status_reg;
    logic [31:0]   m_read_value_reg;
    logic [4:0]    m_found_reg;
    logic [4:0]    m_length_reg;

    pll_pkg::pll_cmd_t cmd;
    logic [IW-1:0] pidx;
    logic [PW-1:0] pos_w;
    logic [PW-1:0] count_w;
    logic          ins_pos_ok;
    logic          rd_pos_ok;
    logic          out_load;
    logic [4:0]    found;
    logic [CW+4:0] count_ext;

    logic [31:0]   cell_data  [CAPACITY];
    logic          cell_match [CAPACITY];

    // Position checks against the current length.
    assign pos_w      = PW'(pos_reg);
    assign count_w    = PW'(count_reg);
    assign pidx       = IW'(pos_reg - 8'd1);
    assign ins_pos_ok = (pos_reg != 8'd0) && (pos_w <= count_w + PW'(1));
    assign rd_pos_ok  = (pos_reg != 8'd0) && (pos_w <= count_w);

    // Command for the cell chain; exec, ins and del are live only in the execute cycle.
    always_comb begin
        cmd.exec = (state_reg == pll_pkg::PLL_EXEC);
        cmd.ins  = cmd.exec && (op_reg == pll_pkg::OP_INSERT) && ins_pos_ok
                   && (count_reg < CAP_COUNT);
        cmd.del  = cmd.exec && (op_reg == pll_pkg::OP_DELETE) && rd_pos_ok;
        cmd.cmp  = (op_reg == pll_pkg::OP_LOCATE);
    end

    // Chain of cells; the ends see their own entry as the outside neighbor.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [31:0] left_d;
        logic [31:0] right_d;
        if (i == 0) begin : g_first
            assign left_d = cell_data[i];
        end else begin : g_mid_l
            assign left_d = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_d = cell_data[i];
        end else begin : g_mid_r
            assign right_d = cell_data[i+1];
        end
        pll_cell #(
            .IDX (i),
            .IW  (IW),
            .CW  (CW)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .pidx       (pidx),
            .count      (count_reg),
            .value      (val_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .match      (cell_match[i])
        );
    end

    // Status, read value and new length of the operation in execute.
    always_comb begin
        status_next = status_reg;
        rd_next     = rd_reg;
        count_next  = count_reg;
        if (cmd.exec) begin
            status_next = pll_pkg::ST_OK;
            rd_next     = 32'd0;
            case (op_reg)
                pll_pkg::OP_INSERT: begin
                    if (!ins_pos_ok) begin
                        status_next = pll_pkg::ST_BAD_POS;
                    end else if (count_reg >= CAP_COUNT) begin
                        status_next = pll_pkg::ST_FULL;
                    end else begin
                        count_next = count_reg + CW'(1);
                    end
                end
                pll_pkg::OP_DELETE: begin
                    if (!rd_pos_ok) begin
                        status_next = pll_pkg::ST_BAD_POS;
                    end else begin
                        rd_next    = cell_data[pidx];
                        count_next = count_reg - CW'(1);
                    end
                end
                pll_pkg::OP_GET: begin
                    if (!rd_pos_ok) begin
                        status_next = pll_pkg::ST_BAD_POS;
                    end else begin
                        rd_next = cell_data[pidx];
                    end
                end
                pll_pkg::OP_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // First matching slot; the lowest index wins.
    always_comb begin
        found = 5'd0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (cell_match[i]) begin
                found = 5'(i + 1);
            end
        end
    end

    assign count_ext = {5'd0, count_reg};

    // Sequencer: accept, execute, load result.
    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            pll_pkg::PLL_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = pll_pkg::PLL_EXEC;
                end
            end
            pll_pkg::PLL_EXEC: begin
                state_next = pll_pkg::PLL_RESP;
            end
            pll_pkg::PLL_RESP: begin
                out_load = !m_valid_reg || m_ready;
                if (out_load) begin
                    state_next = pll_pkg::PLL_IDLE;
                end
            end
            default: begin
                state_next = pll_pkg::PLL_IDLE;
            end
        endcase
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pll_pkg::PLL_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Captured input beat and execute results.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= s_operation;
            pos_reg <= s_position;
            val_reg <= s_value;
        end
        status_reg <= status_next;
        rd_reg     <= rd_next;
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg     <= status_reg;
            m_read_value_reg <= rd_reg;
            m_found_reg      <= found;
            m_length_reg     <= count_ext[4:0];
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_read_value     = m_read_value_reg;
    assign m_found_position = m_found_reg;
    assign m_list_length    = m_length_reg;

endmodule
`default_nettype wire

// ----- hdl/pll_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pll_cell: one list slot
// Holds one entry, shifts with its neighbors on insert and delete, and
// compares its entry against the search value on locate.
// ----------------------------------------------------------------------------
module pll_cell #(
    parameter int IDX = 0,
    parameter int IW  = 4,
    parameter int CW  = 5
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire pll_pkg::pll_cmd_t cmd,
    input  wire [IW-1:0]     pidx,
    input  wire [CW-1:0]     count,
    input  wire [31:0]       value,
    input  wire [31:0]       left_data,
    input  wire [31:0]       right_data,
    output logic [31:0]      data,
    output logic             match
);

    localparam logic [IW-1:0] MY_IDX   = IW'(IDX);
    localparam logic [CW-1:0] MY_COUNT = CW'(IDX);

    logic [31:0] data_reg;
    logic [31:0] data_next;
    logic        match_reg;
    logic        match_next;

    // Entry update: load at the insert point, shift up after it on insert,
    // shift down from the delete point on delete.
    always_comb begin
        data_next = data_reg;
        if (cmd.ins) begin
            if (MY_IDX == pidx) begin
                data_next = value;
            end else if (MY_IDX > pidx) begin
                data_next = left_data;
            end
        end else if (cmd.del) begin
            if (MY_IDX >= pidx) begin
                data_next = right_data;
            end
        end
    end

    // Match flag: only occupied slots take part in a locate.
    always_comb begin
        match_next = match_reg;
        if (cmd.exec) begin
            match_next = cmd.cmp && (MY_COUNT < count) && (data_reg == value);
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else begin
            match_reg <= match_next;
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule
`default_nettype wire

// ----- hdl/pll_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pll_checker: port-level checks for the positional list engine
// Watches the top-level ports and flags handshake or result slips.
// ----------------------------------------------------------------------------
module pll_checker #(
    parameter int CAPACITY = 16
) (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_valid,
    input wire        s_ready,
    input wire        m_valid,
    input wire        m_ready,
    input wire [1:0]  m_status,
    input wire [31:0] m_read_value,
    input wire [4:0]  m_found_position,
    input wire [4:0]  m_list_length
);

    // No result is shown right after reset.
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat valid after reset");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_read_value) && $stable(m_list_length))
        else $error("stalled result beat changed");

    // One beat at a time: the block is busy right after accepting.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on two cycles in a row");

    // A failed operation returns no data and no locate hit.
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != pll_pkg::ST_OK |->
            m_read_value == 32'd0 && m_found_position == 5'd0)
        else $error("failed operation returned data");

    // Status code and length stay in range.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == pll_pkg::ST_OK || m_status == pll_pkg::ST_BAD_POS
            || m_status == pll_pkg::ST_FULL) && (32'(m_list_length) <= CAPACITY))
        else $error("result field out of range");

endmodule

bind positional_list_engine pll_checker #(.CAPACITY(CAPACITY)) u_pll_checker (.*);
`default_nettype wire

// ----- dv/pll_list_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pll_list_checker: result checker for the positional list engine
// Watches both channels, keeps a shadow copy of the list, predicts every
// result beat and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module pll_list_checker #(
    parameter int CAPACITY = 16
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    input  wire        s_ready,
    input  wire [2:0]  s_operation,
    input  wire [7:0]  s_position,
    input  wire [31:0] s_value,
    input  wire        m_valid,
    input  wire        m_ready,
    input  wire [1:0]  m_status,
    input  wire [31:0] m_read_value,
    input  wire [4:0]  m_found_position,
    input  wire [4:0]  m_list_length,
    output int         mismatch_count,
    output int         results_checked,
    output int         pending_results,
    output int         list_length_now,
    output int         full_rejects,
    output int         bad_positions,
    output int         locate_hits
);

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_value;
        logic [4:0]  found_position;
        logic [4:0]  list_length;
    } list_result_t;

    // Shadow list and the results still owed by the block.
    logic [31:0]  shadow_cells [CAPACITY];
    int unsigned  shadow_length;
    list_result_t owed_results [$];

    // Apply one operation to the shadow list and work out its result beat.
    task automatic apply_list_op(input logic [2:0] op, input logic [7:0] pos,
                                 input logic [31:0] val, output list_result_t res);
        int j;
        res = '0;
        res.status = pll_pkg::ST_OK;
        case (op)
            pll_pkg::OP_INSERT: begin
                if (pos == 0 || pos > shadow_length + 1) begin
                    res.status = pll_pkg::ST_BAD_POS;
                end else if (shadow_length >= CAPACITY) begin
                    res.status = pll_pkg::ST_FULL;
                end else begin
                    for (j = shadow_length; j >= pos; j--)
                        shadow_cells[j] = shadow_cells[j - 1];
                    shadow_cells[pos - 1] = val;
                    shadow_length++;
                end
            end
            pll_pkg::OP_DELETE: begin
                if (pos == 0 || pos > shadow_length) begin
                    res.status = pll_pkg::ST_BAD_POS;
                end else begin
                    res.read_value = shadow_cells[pos - 1];
                    for (j = pos; j < shadow_length; j++)
                        shadow_cells[j - 1] = shadow_cells[j];
                    shadow_length--;
                end
            end
            pll_pkg::OP_GET: begin
                if (pos == 0 || pos > shadow_length)
                    res.status = pll_pkg::ST_BAD_POS;
                else
                    res.read_value = shadow_cells[pos - 1];
            end
            pll_pkg::OP_LOCATE: begin
                // First match wins.
                for (j = 0; j < shadow_length; j++) begin
                    if (res.found_position == 0 && shadow_cells[j] == val)
                        res.found_position = 5'(j + 1);
                end
            end
            pll_pkg::OP_CLEAR: begin
                shadow_length = 0;
            end
            default: begin
            end
        endcase
        res.list_length = 5'(shadow_length);
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("checker: %s mismatch at result %0d: expected 0x%08h, got 0x%08h",
                     what, results_checked, want_v, got_v);
    endtask

    // Predict on every accepted input beat, check on every accepted result beat.
    always @(posedge aclk) begin : watch
        list_result_t want;
        list_result_t got;
        if (!aresetn) begin
            owed_results.delete();
            shadow_length = 0;
            foreach (shadow_cells[k])
                shadow_cells[k] = '0;
        end else begin
            if (s_valid && s_ready) begin
                apply_list_op(s_operation, s_position, s_value, want);
                owed_results.push_back(want);
            end
            if (m_valid && m_ready) begin
                got = {m_status, m_read_value, m_found_position, m_list_length};
                if (owed_results.size() == 0) begin
                    note_mismatch("unexpected result", '0, got.read_value);
                end else begin
                    want = owed_results.pop_front();
                    if (got.status !== want.status)
                        note_mismatch("status", want.status, got.status);
                    if (got.read_value !== want.read_value)
                        note_mismatch("read_value", want.read_value, got.read_value);
                    if (got.found_position !== want.found_position)
                        note_mismatch("found_position", want.found_position,
                                      got.found_position);
                    if (got.list_length !== want.list_length)
                        note_mismatch("list_length", want.list_length, got.list_length);
                    if (want.status == pll_pkg::ST_FULL)
                        full_rejects++;
                    if (want.status == pll_pkg::ST_BAD_POS)
                        bad_positions++;
                    if (want.found_position != 0)
                        locate_hits++;
                end
                results_checked++;
            end
        end
        pending_results = owed_results.size();
        list_length_now = shadow_length;
    end

endmodule
`default_nettype wire

// ----- dv/positional_list_engine_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine_tb: top-level testbench for the positional list engine
// Drives directed and random list operations under three idle profiles and
// leaves prediction and comparison to the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module positional_list_engine_tb;

    localparam int         LIST_CAPACITY   = 16;
    localparam int         BEATS_PER_PHASE = 550;
    localparam int         CYCLE_LIMIT     = 200000;
    localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;
    localparam logic [31:0] VALUE_MAX      = 32'h7FFF_FFFF;
    localparam logic [31:0] VALUE_MIN      = 32'h8000_0000;
    localparam logic [31:0] VALUE_ALL_ONES = 32'hFFFF_FFFF;

    // Which way the random stream leans the list length.
    typedef enum int {SHAPE_FILL, SHAPE_DRAIN, SHAPE_MIX} shape_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_operation;
    logic [7:0]  s_position;
    logic [31:0] s_value;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [31:0] m_read_value;
    logic [4:0]  m_found_position;
    logic [4:0]  m_list_length;

    int mismatch_count;
    int results_checked;
    int pending_results;
    int list_length_now;
    int full_rejects;
    int bad_positions;
    int locate_hits;

    int     send_gap_pct;
    int     recv_stall_pct;
    int     beats_sent;
    int     cycle_count;
    shape_t shape;

    positional_list_engine #(
        .CAPACITY(LIST_CAPACITY)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_operation(s_operation),
        .s_position(s_position),
        .s_value(s_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_read_value(m_read_value),
        .m_found_position(m_found_position),
        .m_list_length(m_list_length)
    );

    pll_list_checker #(
        .CAPACITY(LIST_CAPACITY)
    ) checker_i (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_operation(s_operation),
        .s_position(s_position),
        .s_value(s_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_read_value(m_read_value),
        .m_found_position(m_found_position),
        .m_list_length(m_list_length),
        .mismatch_count(mismatch_count),
        .results_checked(results_checked),
        .pending_results(pending_results),
        .list_length_now(list_length_now),
        .full_rejects(full_rejects),
        .bad_positions(bad_positions),
        .locate_hits(locate_hits)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_results);
            $display("positional_list_engine_tb: done, errors");
            $finish;
        end
    end

    // Result side backpressure, redrawn every cycle.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one input beat, called right after a falling edge, and hold it
    // until the block takes it.
    task automatic send_beat(input logic [2:0] op, input logic [7:0] pos,
                             input logic [31:0] val);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_position  <= pos;
        s_value     <= val;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        beats_sent++;
    endtask

    task automatic directed_beat(input logic [2:0] op, input logic [7:0] pos,
                                 input logic [31:0] val);
        @(negedge aclk);
        send_beat(op, pos, val);
    endtask

    // Hold the sender off until every owed result has come back.
    task automatic hold_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge aclk);
    endtask

    // Draw one random beat; positions lean toward the current length and
    // values toward a small pool, so shifts, hits and full-list rejects are common.
    task automatic pick_beat(output logic [2:0] op, output logic [7:0] pos,
                             output logic [31:0] val);
        int unsigned len;
        int unsigned r;
        int unsigned hi;
        int unsigned t_ins;
        int unsigned t_del;
        int unsigned t_get;
        len = list_length_now;
        if (len == LIST_CAPACITY && $urandom_range(3) == 0)
            shape = SHAPE_DRAIN;
        else if (len == 0 && shape == SHAPE_DRAIN)
            shape = SHAPE_FILL;
        else if ($urandom_range(99) < 3)
            shape = shape_t'($urandom_range(2));

        case (shape)
            SHAPE_FILL:  begin t_ins = 60; t_del = 70; t_get = 84; end
            SHAPE_DRAIN: begin t_ins = 10; t_del = 70; t_get = 84; end
            default:     begin t_ins = 30; t_del = 55; t_get = 77; end
        endcase

        r = $urandom_range(99);
        if (r < 2) begin
            op = pll_pkg::OP_CLEAR;
        end else if (r < 5) begin
            op = 3'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
        end else begin
            r = $urandom_range(99);
            if (r < t_ins)
                op = pll_pkg::OP_INSERT;
            else if (r < t_del)
                op = pll_pkg::OP_DELETE;
            else if (r < t_get)
                op = pll_pkg::OP_GET;
            else
                op = pll_pkg::OP_LOCATE;
        end

        // Highest legal position for this operation.
        if (op == pll_pkg::OP_INSERT)
            hi = len + 1;
        else
            hi = (len == 0) ? 1 : len;
        r = $urandom_range(99);
        if (r < 80) begin
            pos = 8'($urandom_range(hi, 1));
        end else if (r < 90) begin
            case ($urandom_range(2))
                0:       pos = '0;
                1:       pos = 8'(hi + 1);
                default: pos = 8'(hi);
            endcase
        end else begin
            pos = 8'($urandom_range(255, 0));
        end

        // A small value pool makes locate hits and duplicates common.
        r = $urandom_range(99);
        if (r < 45) begin
            val = 32'($signed($urandom_range(7, 0)) - 3);
        end else if (r < 55) begin
            case ($urandom_range(3))
                0:       val = VALUE_MAX;
                1:       val = VALUE_MIN;
                2:       val = '0;
                default: val = VALUE_ALL_ONES;
            endcase
        end else begin
            val = $urandom;
        end
    endtask

    initial begin : stimulus
        logic [2:0]  op;
        logic [7:0]  pos;
        logic [31:0] val;
        int          phase;
        int          n;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_operation    = pll_pkg::OP_INSERT;
        s_position     = '0;
        s_value        = '0;
        m_ready        = 1'b0;
        send_gap_pct   = 11;
        recv_stall_pct = 66;
        shape          = SHAPE_FILL;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty list, bad positions, signed extremes, shifts,
        // first-match locate, unused codes and clear.
        directed_beat(pll_pkg::OP_GET,    8'd0,   '0);
        directed_beat(pll_pkg::OP_DELETE, 8'd1,   '0);
        directed_beat(pll_pkg::OP_LOCATE, 8'd0,   '0);
        directed_beat(pll_pkg::OP_INSERT, 8'd0,   32'd5);
        directed_beat(pll_pkg::OP_INSERT, 8'd2,   32'd6);
        directed_beat(pll_pkg::OP_INSERT, 8'd1,   VALUE_MAX);
        directed_beat(pll_pkg::OP_INSERT, 8'd1,   VALUE_MIN);
        directed_beat(pll_pkg::OP_INSERT, 8'd3,   '0);
        directed_beat(pll_pkg::OP_INSERT, 8'd2,   VALUE_ALL_ONES);
        directed_beat(pll_pkg::OP_INSERT, 8'd255, 32'd7);
        directed_beat(pll_pkg::OP_GET,    8'd1,   '0);
        directed_beat(pll_pkg::OP_GET,    8'd4,   '0);
        directed_beat(pll_pkg::OP_GET,    8'd5,   '0);
        directed_beat(pll_pkg::OP_GET,    8'd255, VALUE_ALL_ONES);
        directed_beat(pll_pkg::OP_LOCATE, 8'd0,   VALUE_MAX);
        directed_beat(pll_pkg::OP_LOCATE, 8'd255, 32'd12345);
        directed_beat(pll_pkg::OP_INSERT, 8'd5,   VALUE_MAX);
        directed_beat(pll_pkg::OP_LOCATE, 8'd1,   VALUE_MAX);
        directed_beat(pll_pkg::OP_DELETE, 8'd2,   '0);
        directed_beat(pll_pkg::OP_DELETE, 8'd4,   '0);
        directed_beat(pll_pkg::OP_DELETE, 8'd0,   '0);
        directed_beat(OP_FIRST_UNUSED,        8'd1,   VALUE_MAX);
        directed_beat(OP_FIRST_UNUSED + 3'd1, 8'd255, VALUE_ALL_ONES);
        directed_beat(OP_LAST_UNUSED,         8'd2,   VALUE_MIN);
        directed_beat(pll_pkg::OP_CLEAR,  8'd255, VALUE_ALL_ONES);
        directed_beat(pll_pkg::OP_GET,    8'd1,   '0);

        // Random: light sender gaps with heavy stalls, then the reverse,
        // then full rate on both sides.
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin send_gap_pct = 11; recv_stall_pct = 66; end
                1:       begin send_gap_pct = 66; recv_stall_pct = 11; end
                default: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            endcase
            for (n = 0; n < BEATS_PER_PHASE; n++) begin
                @(negedge aclk);
                pick_beat(op, pos, val);
                send_beat(op, pos, val);
                if (n == BEATS_PER_PHASE / 2)
                    hold_until_drained();
            end
            hold_until_drained();
        end

        // Let any stray result show up before the verdict.
        repeat (20) @(negedge aclk);

        $display("summary: %0d beats sent and %0d results checked over three idle profiles",
                 beats_sent, results_checked);
        $display("summary: %0d full-list rejects, %0d bad positions, %0d locate hits",
                 full_rejects, bad_positions, locate_hits);
        if (mismatch_count == 0 && pending_results == 0)
            $display("positional_list_engine_tb: done, clean");
        else
            $display("positional_list_engine_tb: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
